// ===== rtl/core/gprm_pkg.sv =====
// ============================================================================
// gprm_pkg
// Shared types, register codes and helpers of the guard pattern run matcher.
// ============================================================================
package gprm_pkg;

    // Configuration port
    localparam int CFG_DATA_W  = 36;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WIDTHS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WHITE_FIRST    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_IND_VAR    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_AVG_VAR    = 3'd4;

    // Reset values of the configuration registers
    localparam logic [35:0] PATTERN_WIDTHS_RESET = 36'h031111118;
    localparam logic [3:0]  PATTERN_LENGTH_RESET = 4'd8;
    localparam logic        WHITE_FIRST_RESET    = 1'b0;
    localparam logic [9:0]  MAX_IND_VAR_RESET    = 10'd204;
    localparam logic [9:0]  MAX_AVG_VAR_RESET    = 10'd107;

    // The width register holds nine 4-bit elements; the pattern sum stays below 256.
    localparam int NUM_ELEM = 9;
    localparam int PSUM_W   = 8;

    // Entries of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic        pixel;
        logic [11:0] x_pos;
        logic        first_of_row;
        logic        last_of_row;
    } pix_t;

    typedef struct packed {
        logic        found;
        logic [11:0] start_col;
        logic [11:0] end_col;
    } res_t;

    typedef struct packed {
        logic [35:0] pattern_widths;
        logic [3:0]  pattern_length;
        logic        white_first;
        logic [9:0]  max_individual_variance;
        logic [9:0]  max_avg_variance;
    } cfg_t;

    // One classified pixel: cont is high when the pixel extends the current run.
    typedef struct packed {
        logic        first;
        logic        last;
        logic        cont;
        logic [11:0] x;
    } event_t;

    typedef struct packed {
        logic done;
        logic match;
    } chk_status_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CHECK,
        B_FINISH
    } back_state_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_SUM,
        C_TEST,
        C_DIV,
        C_LIMIT,
        C_VMUL,
        C_VDIFF,
        C_AVG
    } chk_state_t;

    // Expected width of element idx; elements past the ninth are zero.
    function automatic logic [3:0] elem_width(input logic [35:0] widths,
                                              input logic [3:0]  idx);
        logic [35:0] shifted;
        shifted = widths >> {idx, 2'b00};
        if (idx >= 4'(NUM_ELEM)) begin
            return 4'd0;
        end
        return shifted[3:0];
    endfunction

endpackage

// ===== rtl/core/gprm_front.sv =====
// ============================================================================
// gprm_front
// Classifies each incoming pixel against the expected run colour.
// ============================================================================
module gprm_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pix_valid,
    input  gprm_pkg::pix_t   pix_data,
    output logic             pix_stall,
    input  logic             white_first,
    output logic             ev_valid,
    output gprm_pkg::event_t ev_data,
    input  logic             ev_full
);

    logic expect_white_reg;
    logic expect_white_next;
    logic expect_now;
    logic cont;

    // The colour only flips when a run ends, whatever the check says; after a
    // match the back ignores everything until the next row restarts this flop.
    always_comb
    begin
        expect_now = pix_data.first_of_row ? white_first : expect_white_reg;
        cont       = pix_data.pixel ^ expect_now;
        expect_white_next = expect_white_reg;
        if (pix_valid && !ev_full) begin
            expect_white_next = cont ? expect_now : ~expect_now;
        end
    end

    assign pix_stall     = ev_full;
    assign ev_valid      = pix_valid;
    assign ev_data.first = pix_data.first_of_row;
    assign ev_data.last  = pix_data.last_of_row;
    assign ev_data.cont  = cont;
    assign ev_data.x     = pix_data.x_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            expect_white_reg <= gprm_pkg::WHITE_FIRST_RESET;
        end
        else begin
            expect_white_reg <= expect_white_next;
        end
    end

endmodule

// ===== rtl/core/gprm_fifo.sv =====
// ============================================================================
// gprm_fifo
// Short queue of classified pixels between the front and the back.
// ============================================================================
module gprm_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  gprm_pkg::event_t push_data,
    output logic             full,
    output logic             pop_valid,
    output gprm_pkg::event_t pop_data,
    input  logic             pop
);

    localparam int PTRW = $clog2(gprm_pkg::QUEUE_DEPTH);
    localparam int CNTW = $clog2(gprm_pkg::QUEUE_DEPTH + 1);

    gprm_pkg::event_t        mem_reg [gprm_pkg::QUEUE_DEPTH];
    logic [PTRW-1:0]         wr_ptr_reg;
    logic [PTRW-1:0]         wr_ptr_next;
    logic [PTRW-1:0]         rd_ptr_reg;
    logic [PTRW-1:0]         rd_ptr_next;
    logic [CNTW-1:0]         count_reg;
    logic [CNTW-1:0]         count_next;
    logic                    do_push;
    logic                    do_pop;

    assign full      = (count_reg == CNTW'(gprm_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(gprm_pkg::QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTRW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(gprm_pkg::QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTRW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNTW'(1);
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/gprm_check.sv =====
// ============================================================================
// gprm_check
// Multi-cycle window check: scales the pattern to the measured total and tests
// per-element and average variance; adds one element or finds one quotient bit a cycle.
// ============================================================================
module gprm_check #(
    parameter int MAX_PATTERN = 9,
    parameter int ROW_WIDTH   = 4096
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          start,
    input  logic [MAX_PATTERN-1:0][$clog2(ROW_WIDTH+1)-1:0] counts,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]              n,
    input  logic [35:0]                                   pattern_widths,
    input  logic [9:0]                                    max_individual_variance,
    input  logic [9:0]                                    max_avg_variance,
    output gprm_pkg::chk_status_t                         status
);

    localparam int CW   = $clog2(ROW_WIDTH + 1);
    localparam int TW   = $clog2(MAX_PATTERN * ROW_WIDTH + 1);
    localparam int UW   = TW + 8;
    localparam int VW   = UW + 4;
    localparam int TVW  = VW + 4;
    localparam int LW   = UW + 2;
    localparam int PW   = gprm_pkg::PSUM_W;
    localparam int STW  = $clog2(UW);
    localparam int AW   = TW + 10;

    gprm_pkg::chk_state_t             state_reg;
    gprm_pkg::chk_state_t             state_next;
    logic [STW-1:0]                   step_reg;
    logic [STW-1:0]                   step_next;
    logic [MAX_PATTERN-1:0][CW-1:0]   snap_reg;
    logic [MAX_PATTERN-1:0][CW-1:0]   snap_next;
    logic [TW-1:0]                    total_reg;
    logic [TW-1:0]                    total_next;
    logic [PW-1:0]                    psum_reg;
    logic [PW-1:0]                    psum_next;
    logic [UW-1:0]                    div_reg;
    logic [UW-1:0]                    div_next;
    logic [PW-1:0]                    rem_reg;
    logic [PW-1:0]                    rem_next;
    logic [LW-1:0]                    limit_reg;
    logic [LW-1:0]                    limit_next;
    logic [VW-1:0]                    s_reg;
    logic [VW-1:0]                    s_next;
    logic [VW-1:0]                    c_reg;
    logic [VW-1:0]                    c_next;
    logic [TVW-1:0]                   tv_reg;
    logic [TVW-1:0]                   tv_next;
    logic [AW-1:0]                    prod_reg;
    logic [AW-1:0]                    prod_next;
    logic                             done_reg;
    logic                             done_next;
    logic                             match_reg;
    logic                             match_next;

    logic [CW-1:0]                    head;
    logic [3:0]                       w;
    logic                             active;
    logic                             last_elem;
    logic                             last_div;
    logic                             test_fail;
    logic [PW:0]                      trial;
    logic                             q_bit;
    logic [UW+9:0]                    lim_prod;
    logic [VW-1:0]                    mul_s;
    logic [VW-1:0]                    diff;
    logic                             v_over;
    logic [AW-1:0]                    avg_prod;

    always_comb
    begin
        head      = snap_reg[0];
        w         = gprm_pkg::elem_width(pattern_widths, 4'(step_reg));
        active    = int'(step_reg) < int'(n);
        last_elem = (step_reg == STW'(MAX_PATTERN - 1));
        last_div  = (step_reg == STW'(UW - 1));
        test_fail = (psum_reg == '0) || (total_reg < TW'(psum_reg));
        trial     = {rem_reg, div_reg[UW-1]};
        q_bit     = (trial >= {1'b0, psum_reg});
        lim_prod  = (UW+10)'(div_reg) * (UW+10)'(max_individual_variance);
        mul_s     = VW'(w) * VW'(div_reg);
        diff      = (c_reg > s_reg) ? (c_reg - s_reg) : (s_reg - c_reg);
        v_over    = (diff > VW'(limit_reg));
        avg_prod  = AW'(total_reg) * AW'(max_avg_variance);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gprm_pkg::C_IDLE:
            begin
                if (start) begin
                    state_next = gprm_pkg::C_SUM;
                end
            end
            gprm_pkg::C_SUM:
            begin
                if (last_elem) begin
                    state_next = gprm_pkg::C_TEST;
                end
            end
            gprm_pkg::C_TEST:
            begin
                state_next = test_fail ? gprm_pkg::C_IDLE : gprm_pkg::C_DIV;
            end
            gprm_pkg::C_DIV:
            begin
                if (last_div) begin
                    state_next = gprm_pkg::C_LIMIT;
                end
            end
            gprm_pkg::C_LIMIT:
            begin
                state_next = gprm_pkg::C_VMUL;
            end
            gprm_pkg::C_VMUL:
            begin
                state_next = gprm_pkg::C_VDIFF;
            end
            gprm_pkg::C_VDIFF:
            begin
                if (active && v_over) begin
                    state_next = gprm_pkg::C_IDLE;
                end
                else if (last_elem) begin
                    state_next = gprm_pkg::C_AVG;
                end
                else begin
                    state_next = gprm_pkg::C_VMUL;
                end
            end
            gprm_pkg::C_AVG:
            begin
                state_next = gprm_pkg::C_IDLE;
            end
            default:
            begin
                state_next = gprm_pkg::C_IDLE;
            end
        endcase
    end

    // Datapath
    always_comb
    begin
        step_next  = step_reg;
        snap_next  = snap_reg;
        total_next = total_reg;
        psum_next  = psum_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        limit_next = limit_reg;
        s_next     = s_reg;
        c_next     = c_reg;
        tv_next    = tv_reg;
        prod_next  = prod_reg;
        done_next  = 1'b0;
        match_next = match_reg;
        case (state_reg)
            gprm_pkg::C_IDLE:
            begin
                if (start) begin
                    snap_next  = counts;
                    step_next  = '0;
                    total_next = '0;
                    psum_next  = '0;
                    tv_next    = '0;
                end
            end
            gprm_pkg::C_SUM:
            begin
                if (active) begin
                    total_next = total_reg + TW'(head);
                    psum_next  = psum_reg + PW'(w);
                end
                // A full rotation leaves the snapshot in its original order.
                snap_next = {snap_reg[0], snap_reg[MAX_PATTERN-1:1]};
                step_next = last_elem ? '0 : step_reg + STW'(1);
            end
            gprm_pkg::C_TEST:
            begin
                if (test_fail) begin
                    done_next  = 1'b1;
                    match_next = 1'b0;
                end
                div_next  = {total_reg, 8'h00};
                rem_next  = '0;
                step_next = '0;
            end
            gprm_pkg::C_DIV:
            begin
                // Restoring division; quotient bits shift in where dividend bits leave.
                rem_next  = q_bit ? PW'(trial - {1'b0, psum_reg}) : PW'(trial);
                div_next  = {div_reg[UW-2:0], q_bit};
                step_next = last_div ? '0 : step_reg + STW'(1);
            end
            gprm_pkg::C_LIMIT:
            begin
                limit_next = lim_prod[UW+9:8];
                step_next  = '0;
            end
            gprm_pkg::C_VMUL:
            begin
                s_next = mul_s;
                c_next = VW'({head, 8'h00});
            end
            gprm_pkg::C_VDIFF:
            begin
                if (active && v_over) begin
                    done_next  = 1'b1;
                    match_next = 1'b0;
                end
                if (active) begin
                    tv_next = tv_reg + TVW'(diff);
                end
                snap_next = {snap_reg[0], snap_reg[MAX_PATTERN-1:1]};
                step_next = last_elem ? '0 : step_reg + STW'(1);
                prod_next = avg_prod;
            end
            gprm_pkg::C_AVG:
            begin
                // floor(tv / total) < limit is the same as tv < limit * total.
                done_next  = 1'b1;
                match_next = (tv_reg < TVW'(prod_reg));
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    assign status.done  = done_reg;
    assign status.match = match_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= gprm_pkg::C_IDLE;
            done_reg  <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        snap_reg  <= snap_next;
        total_reg <= total_next;
        psum_reg  <= psum_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        limit_reg <= limit_next;
        s_reg     <= s_next;
        c_reg     <= c_next;
        tv_reg    <= tv_next;
        prod_reg  <= prod_next;
        match_reg <= match_next;
    end

endmodule

// ===== rtl/core/gprm_back.sv =====
// ============================================================================
// gprm_back
// Run window: counts runs, starts window checks, slides the window and
// drives the result register.
// ============================================================================
module gprm_back #(
    parameter int MAX_PATTERN = 9,
    parameter int ROW_WIDTH   = 4096
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  gprm_pkg::cfg_t                                  cfg,
    input  logic                                            ev_valid,
    input  gprm_pkg::event_t                                ev_data,
    output logic                                            ev_pop,
    output logic                                            chk_start,
    output logic [MAX_PATTERN-1:0][$clog2(ROW_WIDTH+1)-1:0] chk_counts,
    output logic [$clog2(MAX_PATTERN+1)-1:0]                chk_n,
    input  gprm_pkg::chk_status_t                           chk_status,
    output logic                                            res_valid,
    output gprm_pkg::res_t                                  res_data,
    input  logic                                            res_stall
);

    localparam int CW = $clog2(ROW_WIDTH + 1);
    localparam int IW = $clog2(MAX_PATTERN);
    localparam int NW = $clog2(MAX_PATTERN + 1);

    gprm_pkg::back_state_t           state_reg;
    gprm_pkg::back_state_t           state_next;
    logic [MAX_PATTERN-1:0][CW-1:0]  counts_reg;
    logic [MAX_PATTERN-1:0][CW-1:0]  counts_next;
    logic [IW-1:0]                   run_index_reg;
    logic [IW-1:0]                   run_index_next;
    logic [11:0]                     window_start_reg;
    logic [11:0]                     window_start_next;
    logic                            row_done_reg;
    logic                            row_done_next;
    logic [11:0]                     pend_x_reg;
    logic [11:0]                     pend_x_next;
    logic                            pend_last_reg;
    logic                            pend_last_next;
    logic                            match_reg;
    logic                            match_next;
    logic                            res_valid_reg;
    logic                            res_valid_next;
    gprm_pkg::res_t                  res_data_reg;
    gprm_pkg::res_t                  res_data_next;

    logic [4:0]                      n5;
    logic [NW-1:0]                   n;
    logic [IW-1:0]                   last_idx;
    logic [IW-1:0]                   idx_base;
    logic [IW-1:0]                   idx;
    logic                            done_eff;
    logic                            is_check;
    logic                            ev_out;
    logic                            out_free;
    logic                            fin_out;
    logic                            fin_go;
    logic [MAX_PATTERN-1:0][CW-1:0]  base;
    logic [MAX_PATTERN-1:0][CW-1:0]  shifted;

    always_comb
    begin
        n5 = {1'b0, cfg.pattern_length};
        if (n5 < 5'd2) begin
            n5 = 5'd2;
        end
        else if (n5 > 5'(MAX_PATTERN)) begin
            n5 = 5'(MAX_PATTERN);
        end
        n        = NW'(n5);
        last_idx = IW'(n - NW'(1));
        idx_base = ev_data.first ? '0 : run_index_reg;
        // A run index left past the end by a shorter pattern is pulled back.
        idx      = (idx_base > last_idx) ? last_idx : idx_base;
        done_eff = !ev_data.first && row_done_reg;
        is_check = !done_eff && !ev_data.cont && (idx == last_idx);
        ev_out   = !done_eff && ev_data.last && !is_check;
        out_free = !res_valid_reg || !res_stall;
        fin_out  = match_reg || pend_last_reg;
        base     = ev_data.first ? '0 : counts_reg;
        shifted  = counts_reg >> (2 * CW);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gprm_pkg::B_IDLE:
            begin
                if (chk_start) begin
                    state_next = gprm_pkg::B_CHECK;
                end
            end
            gprm_pkg::B_CHECK:
            begin
                if (chk_status.done) begin
                    state_next = gprm_pkg::B_FINISH;
                end
            end
            gprm_pkg::B_FINISH:
            begin
                if (fin_go) begin
                    state_next = gprm_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = gprm_pkg::B_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        ev_pop    = 1'b0;
        chk_start = 1'b0;
        fin_go    = 1'b0;
        case (state_reg)
            gprm_pkg::B_IDLE:
            begin
                ev_pop    = ev_valid && (!ev_out || out_free);
                chk_start = ev_valid && (!ev_out || out_free) && is_check;
            end
            gprm_pkg::B_FINISH:
            begin
                fin_go = !fin_out || out_free;
            end
            default:
            begin
                ev_pop = 1'b0;
            end
        endcase
    end

    // Datapath
    always_comb
    begin
        counts_next       = counts_reg;
        run_index_next    = run_index_reg;
        window_start_next = window_start_reg;
        row_done_next     = row_done_reg;
        pend_x_next       = pend_x_reg;
        pend_last_next    = pend_last_reg;
        match_next        = match_reg;
        res_valid_next    = res_valid_reg && res_stall;
        res_data_next     = res_data_reg;

        if (ev_pop && !is_check) begin
            counts_next = base;
            if (ev_data.first) begin
                window_start_next = ev_data.x;
                row_done_next     = 1'b0;
            end
            if (!done_eff) begin
                if (ev_data.cont) begin
                    for (int k = 0; k < MAX_PATTERN; k++) begin
                        if (IW'(k) == idx && base[k] < CW'(ROW_WIDTH)) begin
                            counts_next[k] = base[k] + CW'(1);
                        end
                    end
                    run_index_next = idx;
                end
                else begin
                    for (int k = 0; k < MAX_PATTERN; k++) begin
                        if (IW'(k) == idx + IW'(1)) begin
                            counts_next[k] = CW'(1);
                        end
                    end
                    run_index_next = idx + IW'(1);
                end
            end
            if (ev_out) begin
                res_valid_next = 1'b1;
                res_data_next  = '0;
            end
        end

        if (chk_start) begin
            pend_x_next    = ev_data.x;
            pend_last_next = ev_data.last;
        end

        if (state_reg == gprm_pkg::B_CHECK && chk_status.done) begin
            match_next = chk_status.match;
        end

        if (fin_go) begin
            if (match_reg) begin
                row_done_next           = 1'b1;
                res_valid_next          = 1'b1;
                res_data_next.found     = 1'b1;
                res_data_next.start_col = window_start_reg;
                res_data_next.end_col   = pend_x_reg;
            end
            else begin
                // Failed check: drop the first two runs and open a new one.
                window_start_next = window_start_reg + 12'(counts_reg[0])
                                  + 12'(counts_reg[1]);
                for (int k = 0; k < MAX_PATTERN; k++) begin
                    if (k + 2 < int'(n)) begin
                        counts_next[k] = shifted[k];
                    end
                    else if (k == int'(n) - 2) begin
                        counts_next[k] = CW'(1);
                    end
                    else if (k == int'(n) - 1) begin
                        counts_next[k] = '0;
                    end
                end
                run_index_next = IW'(n - NW'(2));
                if (pend_last_reg) begin
                    res_valid_next = 1'b1;
                    res_data_next  = '0;
                end
            end
        end
    end

    assign chk_counts = counts_reg;
    assign chk_n      = n;
    assign res_valid  = res_valid_reg;
    assign res_data   = res_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= gprm_pkg::B_IDLE;
            counts_reg       <= '0;
            run_index_reg    <= '0;
            window_start_reg <= '0;
            row_done_reg     <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else begin
            state_reg        <= state_next;
            counts_reg       <= counts_next;
            run_index_reg    <= run_index_next;
            window_start_reg <= window_start_next;
            row_done_reg     <= row_done_next;
            res_valid_reg    <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_x_reg    <= pend_x_next;
        pend_last_reg <= pend_last_next;
        match_reg     <= match_next;
        res_data_reg  <= res_data_next;
    end

endmodule

// ===== rtl/core/guard_pattern_run_matcher.sv =====
// ============================================================================
// guard_pattern_run_matcher
// Measures alternating bar/space runs of one scan row and matches them
// against a configured guard pattern by run-length variance.
// ============================================================================
//
//  Channel  Signals                          Request
//  -------  -------------------------------  ------------------------------
//  pixel    pix_valid, pix_stall, pix_data   one binarized pixel of a row
//  result   res_valid, res_stall, res_data   match columns or row-end miss
//  config   cfg_we, cfg_index, cfg_data      one register write, no wait
//
// A pixel that extends a run, or ends one while the window is not yet full,
// is handled in the back without a check. A pixel that ends a run with a
// full window starts a check that runs the one-bit-a-cycle divider and the
// element-by-element variance pass; the back takes no new pixel until the
// check is done, and a four-entry queue keeps the front accepting pixels
// until it is full. Reset clears all control state at once.
// A stalled result holds in its output register while the queue keeps filling.
//
module guard_pattern_run_matcher #(
    parameter int MAX_PATTERN = 9,
    parameter int ROW_WIDTH   = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pix_valid,
    output logic                                pix_stall,
    input  gprm_pkg::pix_t                      pix_data,
    output logic                                res_valid,
    input  logic                                res_stall,
    output gprm_pkg::res_t                      res_data,
    input  logic                                cfg_we,
    input  logic [gprm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gprm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW = $clog2(ROW_WIDTH + 1);
    localparam int NW = $clog2(MAX_PATTERN + 1);

    gprm_pkg::cfg_t                  cfg_reg;
    gprm_pkg::cfg_t                  cfg_next;

    logic                            fe_valid;
    gprm_pkg::event_t                fe_data;
    logic                            q_full;
    logic                            q_valid;
    gprm_pkg::event_t                q_data;
    logic                            q_pop;
    logic                            chk_start;
    logic [MAX_PATTERN-1:0][CW-1:0]  chk_counts;
    logic [NW-1:0]                   chk_n;
    gprm_pkg::chk_status_t           chk_status;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                gprm_pkg::CFG_PATTERN_WIDTHS: cfg_next.pattern_widths = cfg_data;
                gprm_pkg::CFG_PATTERN_LENGTH: cfg_next.pattern_length = cfg_data[3:0];
                gprm_pkg::CFG_WHITE_FIRST:    cfg_next.white_first    = cfg_data[0];
                gprm_pkg::CFG_MAX_IND_VAR:
                    cfg_next.max_individual_variance = cfg_data[9:0];
                gprm_pkg::CFG_MAX_AVG_VAR:    cfg_next.max_avg_variance = cfg_data[9:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.pattern_widths          <= gprm_pkg::PATTERN_WIDTHS_RESET;
            cfg_reg.pattern_length          <= gprm_pkg::PATTERN_LENGTH_RESET;
            cfg_reg.white_first             <= gprm_pkg::WHITE_FIRST_RESET;
            cfg_reg.max_individual_variance <= gprm_pkg::MAX_IND_VAR_RESET;
            cfg_reg.max_avg_variance        <= gprm_pkg::MAX_AVG_VAR_RESET;
        end
        else begin
            cfg_reg <= cfg_next;
        end
    end

    gprm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_valid   (pix_valid),
        .pix_data    (pix_data),
        .pix_stall   (pix_stall),
        .white_first (cfg_reg.white_first),
        .ev_valid    (fe_valid),
        .ev_data     (fe_data),
        .ev_full     (q_full)
    );

    gprm_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_data  (fe_data),
        .full       (q_full),
        .pop_valid  (q_valid),
        .pop_data   (q_data),
        .pop        (q_pop)
    );

    gprm_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .ROW_WIDTH   (ROW_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .ev_valid   (q_valid),
        .ev_data    (q_data),
        .ev_pop     (q_pop),
        .chk_start  (chk_start),
        .chk_counts (chk_counts),
        .chk_n      (chk_n),
        .chk_status (chk_status),
        .res_valid  (res_valid),
        .res_data   (res_data),
        .res_stall  (res_stall)
    );

    gprm_check #(
        .MAX_PATTERN (MAX_PATTERN),
        .ROW_WIDTH   (ROW_WIDTH)
    ) u_check (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .start                   (chk_start),
        .counts                  (chk_counts),
        .n                       (chk_n),
        .pattern_widths          (cfg_reg.pattern_widths),
        .max_individual_variance (cfg_reg.max_individual_variance),
        .max_avg_variance        (cfg_reg.max_avg_variance),
        .status                  (chk_status)
    );

endmodule
